// ===== hdl/ccv_pkg.sv =====
// ccv_pkg: shared types, constants and helper functions of the coordinate converter
// no dependencies; used by every module under hdl
package ccv_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int GUARD_BITS            = 24;
  localparam int DW                    = 64;
  localparam int ZW                    = 40;
  localparam int QDEPTH                = 2;

  localparam logic [31:0]          INV_GAIN_Q32 = 32'h9B74EDA8;
  localparam logic signed [ZW-1:0] PI_Q32       = 40'sd13493037704;
  localparam logic signed [ZW-1:0] HALF_PI_Q32  = 40'sd6746518852;
  localparam logic signed [ZW-1:0] TWO_PI_Q32   = 40'sd26986075408;

  typedef enum logic [2:0] {
    OP_CART_CYL = 3'd0,
    OP_CART_SPH = 3'd1,
    OP_CYL_CART = 3'd2,
    OP_CYL_SPH  = 3'd3,
    OP_SPH_CART = 3'd4,
    OP_SPH_CYL  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] in_first;
    logic signed [31:0] in_second;
    logic signed [31:0] in_third;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_first;
    logic signed [31:0] out_second;
    logic signed [31:0] out_third;
    logic               degenerate;
    logic               saturated;
  } out_t;

  // classified request as it sits in the queue
  typedef struct packed {
    op_t                op;
    logic               p1_vec;
    logic               p1_use_c;
    logic               p2_vec;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } q_item_t;

  // side data riding along the first cordic pass
  typedef struct packed {
    op_t                op;
    logic               p2_vec;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } s1_t;

  // side data riding along the second cordic pass
  typedef struct packed {
    op_t                op;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [DW-1:0] p;
    logic signed [DW-1:0] q;
  } s2_t;

  function automatic logic signed [ZW-1:0] arc_step(input int i);
    logic signed [ZW-1:0] res;
    case (i)
      0:  res = 40'sd3373259426;
      1:  res = 40'sd1991351318;
      2:  res = 40'sd1052175346;
      3:  res = 40'sd534100635;
      4:  res = 40'sd268086748;
      5:  res = 40'sd134206831;
      6:  res = 40'sd67103403;
      7:  res = 40'sd33553749;
      8:  res = 40'sd16777131;
      9:  res = 40'sd8388597;
      10: res = 40'sd4194303;
      default: begin
        if (i <= 32) res = 40'sd1 <<< (32 - i);
        else         res = '0;
      end
    endcase
    return res;
  endfunction

  // round half up to the output grid and clip; bit 32 flags the clip
  function automatic logic [32:0] coord_out(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    logic [32:0]          res;
    t = (v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    if (t > 64'sd2147483647)       res = {1'b1, 32'h7FFFFFFF};
    else if (t < -64'sd2147483648) res = {1'b1, 32'h80000000};
    else                           res = {1'b0, t[31:0]};
    return res;
  endfunction

  function automatic logic [31:0] angle_out(input logic signed [DW-1:0] z);
    logic signed [DW-1:0] t;
    t = (z + 64'sd8) >>> 4;
    return t[31:0];
  endfunction

endpackage

// ===== hdl/ccv_front.sv =====
// ccv_front: request capture, operation classification and a short request queue
// depends on ccv_pkg
module ccv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ccv_pkg::in_t      in_req,
  output logic              busy,
  input  logic              pop,
  output logic              head_valid,
  output ccv_pkg::q_item_t  head
);

  localparam int PW = $clog2(ccv_pkg::QDEPTH);
  localparam int CW = $clog2(ccv_pkg::QDEPTH + 1);

  logic              acc_valid_r, acc_valid_nxt;
  ccv_pkg::q_item_t  acc_item_r;
  ccv_pkg::q_item_t  cls;
  ccv_pkg::q_item_t  q_mem [0:ccv_pkg::QDEPTH-1];
  logic [PW-1:0]     wptr_r, rptr_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              full, push, do_pop, accept;

  always_comb begin
    cls          = '0;
    cls.op       = ccv_pkg::op_t'(in_req.operation);
    cls.p1_vec   = (cls.op == ccv_pkg::OP_CART_CYL) || (cls.op == ccv_pkg::OP_CART_SPH);
    cls.p1_use_c = (cls.op == ccv_pkg::OP_SPH_CART) || (cls.op == ccv_pkg::OP_SPH_CYL);
    cls.p2_vec   = (cls.op == ccv_pkg::OP_CART_SPH) || (cls.op == ccv_pkg::OP_CYL_SPH);
    cls.a        = in_req.in_first;
    cls.b        = in_req.in_second;
    cls.c        = in_req.in_third;
  end

  assign full       = (cnt_r == CW'(ccv_pkg::QDEPTH));
  assign busy       = acc_valid_r && full;
  assign accept     = start && !busy;
  assign push       = acc_valid_r && !full;
  assign head_valid = (cnt_r != '0);
  assign do_pop     = pop && head_valid;
  assign head       = q_mem[rptr_r];

  always_comb begin
    acc_valid_nxt = acc_valid_r;
    if (accept)    acc_valid_nxt = 1'b1;
    else if (push) acc_valid_nxt = 1'b0;
    cnt_nxt = cnt_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
      cnt_r       <= '0;
      wptr_r      <= '0;
      rptr_r      <= '0;
    end else begin
      acc_valid_r <= acc_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (push)   wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) acc_item_r <= cls;
    if (push)   q_mem[wptr_r] <= acc_item_r;
  end

endmodule

// ===== hdl/ccv_cordic.sv =====
// ccv_cordic: pipelined cordic, vectoring or rotation chosen per request, with gain removal
// depends on ccv_pkg
module ccv_cordic #(
  parameter int  ITER   = ccv_pkg::CORDIC_ITERATIONS_DEF,
  parameter type SIDE_T = logic
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_vec,
  input  logic signed [ccv_pkg::DW-1:0] in_x,
  input  logic signed [ccv_pkg::DW-1:0] in_y,
  input  logic signed [31:0]            in_ang,
  input  SIDE_T                         in_side,
  output logic                          out_valid,
  output logic signed [ccv_pkg::DW-1:0] out_x,
  output logic signed [ccv_pkg::DW-1:0] out_y,
  output logic signed [ccv_pkg::ZW-1:0] out_ang,
  output logic                          out_zero,
  output SIDE_T                         out_side
);

  localparam int DW = ccv_pkg::DW;
  localparam int ZW = ccv_pkg::ZW;

  logic signed [DW-1:0] px, py;
  logic signed [ZW-1:0] pz, wz;
  logic                 pzero;

  logic                 vld_r  [0:ITER];
  logic                 vec_r  [0:ITER];
  logic                 zero_r [0:ITER];
  logic signed [DW-1:0] x_r    [0:ITER];
  logic signed [DW-1:0] y_r    [0:ITER];
  logic signed [ZW-1:0] z_r    [0:ITER];
  SIDE_T                side_r [0:ITER];

  // pre-rotation: quadrant fold for vectoring, angle wrap and fold for rotation
  always_comb begin
    px    = in_x;
    py    = in_y;
    pz    = '0;
    pzero = 1'b0;
    wz    = ZW'(in_ang) <<< 4;
    if (in_vec) begin
      pzero = (in_x == 0) && (in_y == 0);
      if (in_x < 0) begin
        pz = (in_y >= 0) ? ccv_pkg::PI_Q32 : -ccv_pkg::PI_Q32;
        px = -in_x;
        py = -in_y;
      end
    end else begin
      py = '0;
      pz = wz;
      if (pz > ccv_pkg::PI_Q32)  pz = pz - ccv_pkg::TWO_PI_Q32;
      if (pz < -ccv_pkg::PI_Q32) pz = pz + ccv_pkg::TWO_PI_Q32;
      if (pz > ccv_pkg::HALF_PI_Q32) begin
        pz = pz - ccv_pkg::PI_Q32;
        px = -px;
      end
      if (pz < -ccv_pkg::HALF_PI_Q32) begin
        pz = pz + ccv_pkg::PI_Q32;
        px = -px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    vec_r[0]  <= in_vec;
    zero_r[0] <= pzero;
    x_r[0]    <= px;
    y_r[0]    <= py;
    z_r[0]    <= pz;
    side_r[0] <= in_side;
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ARC = ccv_pkg::arc_step(i);
    logic sig_pos;

    // vectoring drives y toward zero, rotation drives z toward zero
    assign sig_pos = vec_r[i] ? !(y_r[i] > 0) : (z_r[i] >= 0);

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
    end

    always_ff @(posedge clk) begin
      vec_r[i+1]  <= vec_r[i];
      zero_r[i+1] <= zero_r[i];
      side_r[i+1] <= side_r[i];
      if (sig_pos) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ARC;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ARC;
      end
    end
  end

  // gain removal: magnitude split, two 32x32 products per axis, recombine
  logic                 p1_vld_r, p2_vld_r, p3_vld_r;
  logic                 p1_zero_r, p2_zero_r;
  logic                 p1_nx_r, p1_ny_r, p2_nx_r, p2_ny_r;
  logic [DW-1:0]        p1_mx_r, p1_my_r;
  logic signed [ZW-1:0] p1_ang_r, p2_ang_r, p3_ang_r;
  logic [DW-1:0]        p2_hx_r, p2_lx_r, p2_hy_r, p2_ly_r;
  logic signed [DW-1:0] p3_x_r, p3_y_r;
  logic                 p3_zero_r;
  SIDE_T                p1_side_r, p2_side_r, p3_side_r;
  logic signed [ZW-1:0] zclamp;
  logic [DW-1:0]        rx, ry;

  always_comb begin
    zclamp = z_r[ITER];
    if (zclamp > ccv_pkg::PI_Q32)  zclamp = ccv_pkg::PI_Q32;
    if (zclamp < -ccv_pkg::PI_Q32) zclamp = -ccv_pkg::PI_Q32;
    rx = p2_hx_r + (p2_lx_r >> 32);
    ry = p2_hy_r + (p2_ly_r >> 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= vld_r[ITER];
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_zero_r <= zero_r[ITER];
    p1_side_r <= side_r[ITER];
    p1_ang_r  <= zclamp;
    p1_nx_r   <= x_r[ITER][DW-1];
    p1_ny_r   <= y_r[ITER][DW-1];
    p1_mx_r   <= x_r[ITER][DW-1] ? DW'(-x_r[ITER]) : DW'(x_r[ITER]);
    p1_my_r   <= y_r[ITER][DW-1] ? DW'(-y_r[ITER]) : DW'(y_r[ITER]);

    p2_zero_r <= p1_zero_r;
    p2_side_r <= p1_side_r;
    p2_ang_r  <= p1_ang_r;
    p2_nx_r   <= p1_nx_r;
    p2_ny_r   <= p1_ny_r;
    p2_hx_r   <= DW'(p1_mx_r[63:32]) * DW'(ccv_pkg::INV_GAIN_Q32);
    p2_lx_r   <= DW'(p1_mx_r[31:0])  * DW'(ccv_pkg::INV_GAIN_Q32);
    p2_hy_r   <= DW'(p1_my_r[63:32]) * DW'(ccv_pkg::INV_GAIN_Q32);
    p2_ly_r   <= DW'(p1_my_r[31:0])  * DW'(ccv_pkg::INV_GAIN_Q32);

    p3_zero_r <= p2_zero_r;
    p3_side_r <= p2_side_r;
    p3_ang_r  <= p2_zero_r ? '0 : p2_ang_r;
    p3_x_r    <= p2_zero_r ? '0 : (p2_nx_r ? -$signed(rx) : $signed(rx));
    p3_y_r    <= p2_ny_r ? -$signed(ry) : $signed(ry);
  end

  assign out_valid = p3_vld_r;
  assign out_x     = p3_x_r;
  assign out_y     = p3_y_r;
  assign out_ang   = p3_ang_r;
  assign out_zero  = p3_zero_r;
  assign out_side  = p3_side_r;

endmodule

// ===== hdl/coordinate_system_converter.sv =====
// coordinate_system_converter: top level, front queue plus two chained cordic passes
// depends on ccv_pkg, ccv_front, ccv_cordic
// throughput: one request per cycle, every request runs through both cordic passes
// busy stays low in operation since the back end drains the queue every cycle
// reset: synchronous active-low rst_n clears all valid flags; no result strobes after it
module coordinate_system_converter #(
  parameter int CORDIC_ITERATIONS = ccv_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ccv_pkg::in_t  in_req,
  output logic          busy,
  output logic          out_valid,
  output ccv_pkg::out_t out_res
);

  localparam int DW = ccv_pkg::DW;
  localparam int ZW = ccv_pkg::ZW;
  localparam int GB = ccv_pkg::GUARD_BITS;

  // front: capture and classify, then queue
  logic             head_valid;
  ccv_pkg::q_item_t head;

  ccv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req     (in_req),
    .busy       (busy),
    .pop        (head_valid),
    .head_valid (head_valid),
    .head       (head)
  );

  // first pass: xy vectoring (cart->cyl/sph) or rotation of (first,0) by an angle
  logic signed [DW-1:0] x1, y1;
  logic signed [31:0]   ang1;
  ccv_pkg::s1_t         side1;

  always_comb begin
    x1          = DW'(head.a) <<< GB;
    y1          = DW'(head.b) <<< GB;
    ang1        = head.p1_use_c ? head.c : head.b;
    side1.op     = head.op;
    side1.p2_vec = head.p2_vec;
    side1.a      = head.a;
    side1.b      = head.b;
    side1.c      = head.c;
  end

  logic                 c1_valid, c1_zero;
  logic signed [DW-1:0] c1_x, c1_y;
  logic signed [ZW-1:0] c1_ang;
  ccv_pkg::s1_t         c1_side;

  ccv_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_T(ccv_pkg::s1_t)) u_pass1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (head_valid),
    .in_vec    (head.p1_vec),
    .in_x      (x1),
    .in_y      (y1),
    .in_ang    (ang1),
    .in_side   (side1),
    .out_valid (c1_valid),
    .out_x     (c1_x),
    .out_y     (c1_y),
    .out_ang   (c1_ang),
    .out_zero  (c1_zero),
    .out_side  (c1_side)
  );

  // second pass: elevation vectoring (rho,z) or the outer rotation of sph->cart
  logic signed [DW-1:0] wa2, abs_wa2, x2, y2;
  logic                 p1_was_vec;
  ccv_pkg::s2_t         side2;

  always_comb begin
    wa2        = DW'(c1_side.a) <<< GB;
    abs_wa2    = wa2[DW-1] ? -wa2 : wa2;
    // cyl->sph takes |rho| straight from the request
    x2         = (c1_side.op == ccv_pkg::OP_CYL_SPH) ? abs_wa2 : c1_x;
    y2         = DW'(c1_side.c) <<< GB;
    p1_was_vec = (c1_side.op == ccv_pkg::OP_CART_CYL) ||
                 (c1_side.op == ccv_pkg::OP_CART_SPH);
    side2.op   = c1_side.op;
    side2.b    = c1_side.b;
    side2.c    = c1_side.c;
    side2.p    = c1_x;
    side2.q    = p1_was_vec ? DW'(c1_ang) : c1_y;
  end

  logic                 c2_valid, c2_zero;
  logic signed [DW-1:0] c2_x, c2_y;
  logic signed [ZW-1:0] c2_ang;
  ccv_pkg::s2_t         c2_side;

  ccv_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_T(ccv_pkg::s2_t)) u_pass2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c1_valid),
    .in_vec    (c1_side.p2_vec),
    .in_x      (x2),
    .in_y      (y2),
    .in_ang    (c1_side.b),
    .in_side   (side2),
    .out_valid (c2_valid),
    .out_x     (c2_x),
    .out_y     (c2_y),
    .out_ang   (c2_ang),
    .out_zero  (c2_zero),
    .out_side  (c2_side)
  );

  // output stage: rounding, clipping and per-operation field selection
  logic signed [DW-1:0] r_v, s_v;
  logic [32:0]          co_p, co_q, co_r, co_s;
  logic [31:0]          ao_q, ao_s;
  logic                 to_sph;
  ccv_pkg::out_t        res_nxt, out_res_r;
  logic                 out_valid_r;

  always_comb begin
    to_sph = (c2_side.op == ccv_pkg::OP_CART_SPH) || (c2_side.op == ccv_pkg::OP_CYL_SPH);
    r_v    = c2_x;
    s_v    = to_sph ? DW'(c2_ang) : c2_y;
    co_p   = ccv_pkg::coord_out(c2_side.p);
    co_q   = ccv_pkg::coord_out(c2_side.q);
    co_r   = ccv_pkg::coord_out(r_v);
    co_s   = ccv_pkg::coord_out(s_v);
    ao_q   = ccv_pkg::angle_out(c2_side.q);
    ao_s   = ccv_pkg::angle_out(s_v);

    res_nxt = '0;
    case (c2_side.op)
      ccv_pkg::OP_CART_CYL: begin
        res_nxt.out_first  = co_p[31:0];
        res_nxt.out_second = ao_q;
        res_nxt.out_third  = c2_side.c;
        res_nxt.saturated  = co_p[32];
      end
      ccv_pkg::OP_CART_SPH: begin
        res_nxt.out_first  = co_r[31:0];
        res_nxt.out_second = ao_q;
        res_nxt.out_third  = ao_s;
        res_nxt.degenerate = c2_zero;
        res_nxt.saturated  = co_r[32];
      end
      ccv_pkg::OP_CYL_CART: begin
        res_nxt.out_first  = co_p[31:0];
        res_nxt.out_second = co_q[31:0];
        res_nxt.out_third  = c2_side.c;
        res_nxt.saturated  = co_p[32] | co_q[32];
      end
      ccv_pkg::OP_CYL_SPH: begin
        res_nxt.out_first  = co_r[31:0];
        res_nxt.out_second = c2_side.b;
        res_nxt.out_third  = ao_s;
        res_nxt.degenerate = c2_zero;
        res_nxt.saturated  = co_r[32];
      end
      ccv_pkg::OP_SPH_CART: begin
        res_nxt.out_first  = co_r[31:0];
        res_nxt.out_second = co_s[31:0];
        res_nxt.out_third  = co_q[31:0];
        res_nxt.saturated  = co_r[32] | co_s[32] | co_q[32];
      end
      ccv_pkg::OP_SPH_CYL: begin
        res_nxt.out_first  = co_p[31:0];
        res_nxt.out_second = c2_side.b;
        res_nxt.out_third  = co_q[31:0];
        res_nxt.saturated  = co_p[32] | co_q[32];
      end
      default: res_nxt = '0;  // undefined codes give an all-zero result
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= c2_valid;
  end

  always_ff @(posedge clk) begin
    out_res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== hdl/ccv_checker.sv =====
// ccv_checker: port-level checks of the coordinate converter, bound to the top level
// depends on ccv_pkg and coordinate_system_converter
module ccv_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          busy,
  input logic          out_valid,
  input ccv_pkg::out_t out_res
);

  // no result strobe right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // back end drains every cycle, so the front never holds requests off
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> !busy)
    else $error("busy raised");

  // zero length gives radius and elevation of zero
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.degenerate |-> out_res.out_first == 0 && out_res.out_third == 0)
    else $error("degenerate result with nonzero radius or elevation");

  a_deg_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.degenerate |-> !out_res.saturated)
    else $error("degenerate and saturated together");

  // a clip leaves some field at a range limit
  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.saturated |->
      out_res.out_first == 32'sh7FFFFFFF || out_res.out_first == 32'sh80000000 ||
      out_res.out_second == 32'sh7FFFFFFF || out_res.out_second == 32'sh80000000 ||
      out_res.out_third == 32'sh7FFFFFFF || out_res.out_third == 32'sh80000000)
    else $error("saturated flag without a clipped field");

endmodule

bind coordinate_system_converter ccv_checker u_ccv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

// ===== test/coordinate_system_converter_check.sv =====
// coordinate_system_converter_check: watches request and result channels, predicts and compares
// depends on ccv_pkg; instantiated beside the converter by coordinate_system_converter_test
module coordinate_system_converter_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  ccv_pkg::in_t  in_req,
  input  logic          out_valid,
  input  ccv_pkg::out_t out_res,
  output int            errors,
  output int            pending
);

  localparam int ITERS = 24;
  localparam int GUARD = 24;
  localparam longint PI32 = 64'sd13493037704;
  localparam longint HALF_PI32 = 64'sd6746518852;
  localparam longint unsigned INV_K = 64'd2608131496;

  ccv_pkg::out_t converted_q[$];

  function automatic longint arc_angle(int i);
    longint t[11] = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
                      64'sd268086748, 64'sd134206831, 64'sd67103403, 64'sd33553749,
                      64'sd16777131, 64'sd8388597, 64'sd4194303};
    if (i < 11) return t[i];
    if (i <= 32) return 64'sd1 <<< (32 - i);
    return 0;
  endfunction

  // scale by 1/K, truncated toward zero
  function automatic longint ungain(longint v);
    longint unsigned m, r;
    m = (v < 0) ? -v : v;
    r = (m >> 32) * INV_K + (((m & 64'hFFFFFFFF) * INV_K) >> 32);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void to_polar(longint x, longint y, output longint mag,
                                   output longint ang);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? PI32 : -PI32;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arc_angle(i);
      end else begin
        x -= dx; y += dy; z -= arc_angle(i);
      end
    end
    if (z > PI32) z = PI32;
    if (z < -PI32) z = -PI32;
    mag = ungain(x);
    ang = z;
  endfunction

  // r*cos(a), r*sin(a) with the angle in Q3.28
  function automatic void to_cart(longint r, longint a28, output longint cx,
                                  output longint sy);
    longint x, y, z, dx, dy;
    x = r; y = 0; z = a28 * 16;
    if (z > PI32) z -= 2 * PI32;
    if (z < -PI32) z += 2 * PI32;
    if (z > HALF_PI32) begin z -= PI32; x = -x; end
    if (z < -HALF_PI32) begin z += PI32; x = -x; end
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_angle(i);
      end else begin
        x += dx; y -= dy; z += arc_angle(i);
      end
    end
    cx = ungain(x);
    sy = ungain(y);
  endfunction

  function automatic logic [31:0] round_angle(longint z);
    longint t;
    t = (z + 8) >>> 4;
    return t[31:0];
  endfunction

  function automatic logic [31:0] round_coord(longint v, inout logic sat);
    longint t;
    t = (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    if (t > 64'sd2147483647) begin sat = 1'b1; return 32'h7FFFFFFF; end
    if (t < -64'sd2147483648) begin sat = 1'b1; return 32'h80000000; end
    return t[31:0];
  endfunction

  // radius and elevation of (rho,z); zero length flags degenerate
  function automatic void to_elev(longint rho, longint z, output longint rad,
                                  output longint el, inout logic deg);
    if (rho == 0 && z == 0) begin
      rad = 0;
      el = 0;
      deg = 1'b1;
    end else begin
      to_polar(rho, z, rad, el);
    end
  endfunction

  function automatic ccv_pkg::out_t convert(ccv_pkg::in_t r);
    ccv_pkg::out_t o;
    longint wa, wb, wc, p, q, s, t;
    logic deg, sat;
    o = '0;
    deg = 1'b0;
    sat = 1'b0;
    wa = longint'(r.in_first) <<< GUARD;
    wb = longint'(r.in_second) <<< GUARD;
    wc = longint'(r.in_third) <<< GUARD;
    case (r.operation)
      ccv_pkg::OP_CART_CYL: begin
        to_polar(wa, wb, p, q);
        o.out_first = round_coord(p, sat);
        o.out_second = round_angle(q);
        o.out_third = r.in_third;
      end
      ccv_pkg::OP_CART_SPH: begin
        to_polar(wa, wb, p, q);
        to_elev(p, wc, s, t, deg);
        o.out_first = round_coord(s, sat);
        o.out_second = round_angle(q);
        o.out_third = round_angle(t);
      end
      ccv_pkg::OP_CYL_CART: begin
        to_cart(wa, longint'(r.in_second), p, q);
        o.out_first = round_coord(p, sat);
        o.out_second = round_coord(q, sat);
        o.out_third = r.in_third;
      end
      ccv_pkg::OP_CYL_SPH: begin
        to_elev(wa < 0 ? -wa : wa, wc, s, t, deg);
        o.out_first = round_coord(s, sat);
        o.out_second = r.in_second;
        o.out_third = round_angle(t);
      end
      ccv_pkg::OP_SPH_CART: begin
        to_cart(wa, longint'(r.in_third), p, q);
        to_cart(p, longint'(r.in_second), s, t);
        o.out_first = round_coord(s, sat);
        o.out_second = round_coord(t, sat);
        o.out_third = round_coord(q, sat);
      end
      ccv_pkg::OP_SPH_CYL: begin
        to_cart(wa, longint'(r.in_third), p, q);
        o.out_first = round_coord(p, sat);
        o.out_second = r.in_second;
        o.out_third = round_coord(q, sat);
      end
      default: ;
    endcase
    o.degenerate = deg;
    o.saturated = sat;
    return o;
  endfunction

  assign pending = converted_q.size();

  always @(posedge clk) begin
    ccv_pkg::out_t want;
    if (!rst_n) begin
      errors <= 0;
      converted_q.delete();
    end else begin
      if (start && !busy) converted_q.push_back(convert(in_req));
      if (out_valid) begin
        if (converted_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_res);
          errors <= errors + 1;
        end else begin
          want = converted_q.pop_front();
          if (want !== out_res) begin
            $display("%0t: mismatch exp first %h second %h third %h deg %b sat %b",
                     $time, want.out_first, want.out_second, want.out_third,
                     want.degenerate, want.saturated);
            $display("%0t:          got first %h second %h third %h deg %b sat %b",
                     $time, out_res.out_first, out_res.out_second, out_res.out_third,
                     out_res.degenerate, out_res.saturated);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/coordinate_system_converter_test.sv =====
// coordinate_system_converter_test: stimulus and verdict for the coordinate converter
// depends on ccv_pkg, coordinate_system_converter and coordinate_system_converter_check
module coordinate_system_converter_test;

  // pi in Q3.28, rounded down
  localparam int PI_Q28 = 843314856;
  localparam int RANDOM_REQUESTS = 1350;
  localparam int CYCLE_LIMIT = 200000;
  // leave some slack at the end
  localparam int DRAIN_CYCLES = 80;

  logic           clk;
  logic           rst_n;
  logic           start;
  ccv_pkg::in_t   in_req;
  logic           busy;
  logic           out_valid;
  ccv_pkg::out_t  out_res;
  int             errors;
  int             pending;
  int             cycles;

  coordinate_system_converter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_req(in_req),
    .busy(busy), .out_valid(out_valid), .out_res(out_res)
  );

  coordinate_system_converter_check check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog against a stuck handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request with a random idle gap in front; returns at the accepting edge
  task automatic send_request(input logic [2:0] op, input int first, input int second,
                              input int third);
    int gap;
    gap = $urandom_range(0, 3);
    // extra weight on back-to-back requests
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= '{operation: op, in_first: first, in_second: second, in_third: third};
    start <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // angle inside plus or minus pi, now and then a wrap case or full range
  function automatic int rand_angle();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return PI_Q28 + $urandom_range(0, PI_Q28);
      2: return -PI_Q28 - int'($urandom_range(0, PI_Q28));
      default: return int'($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
    endcase
  endfunction

  // coordinate: mostly moderate magnitudes, sometimes tiny, zero or full range
  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 0;
      2: return int'($urandom_range(0, 64)) - 32;
      3: return $urandom() >>> 1 ^ 32'hC0000000;
      default: return int'($urandom_range(0, 32'h1FFFFFF)) - 32'h1000000;
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operation, extremes and corner cases
    send_request(ccv_pkg::OP_CART_CYL, 32'sh00030000, 32'sh00040000, 32'sh00010000);
    send_request(ccv_pkg::OP_CART_CYL, 0, 0, 32'h80000000);        // zero xy vector
    send_request(ccv_pkg::OP_CART_CYL, -32'sh00020000, 0, 7);      // negative x on the axis
    send_request(ccv_pkg::OP_CART_CYL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF); // overflow
    send_request(ccv_pkg::OP_CART_CYL, 32'h80000000, 32'h80000000, 0);
    send_request(ccv_pkg::OP_CART_SPH, 0, 0, 0);                   // zero length
    send_request(ccv_pkg::OP_CART_SPH, 32'sh00010000, -32'sh00010000, 32'sh00010000);
    send_request(ccv_pkg::OP_CART_SPH, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_request(ccv_pkg::OP_CART_SPH, 0, 0, -32'sh00050000);
    send_request(ccv_pkg::OP_CYL_CART, 32'sh00020000, PI_Q28, 3);
    send_request(ccv_pkg::OP_CYL_CART, 32'sh00020000, -PI_Q28 - 1000, 3); // angle wraps
    send_request(ccv_pkg::OP_CYL_CART, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    send_request(ccv_pkg::OP_CYL_CART, 32'h80000000, 32'h80000000, 0);
    send_request(ccv_pkg::OP_CYL_SPH, -32'sh00040000, 32'h12345678, 32'sh00030000); // rho < 0
    send_request(ccv_pkg::OP_CYL_SPH, 0, 32'hFFFFFFFF, 0);
    send_request(ccv_pkg::OP_CYL_SPH, 32'h80000000, 0, 32'h80000000);
    send_request(ccv_pkg::OP_SPH_CART, 32'sh00010000, PI_Q28 / 4, PI_Q28 / 6);
    send_request(ccv_pkg::OP_SPH_CART, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    send_request(ccv_pkg::OP_SPH_CART, 32'h80000000, -PI_Q28, PI_Q28 / 2);
    send_request(ccv_pkg::OP_SPH_CYL, 32'sh00050000, 32'h0BADF00D, -PI_Q28 / 3);
    send_request(ccv_pkg::OP_SPH_CYL, 32'h7FFFFFFF, 0, PI_Q28 + 5);
    send_request(3'd6, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);  // undefined codes
    send_request(3'd7, 32'h80000000, 32'hFFFFFFFF, 1);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // at mid run hold off until the pipeline has fully drained
      if (n == RANDOM_REQUESTS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 7) == 0)
        send_request(op, $urandom(), $urandom(), $urandom());
      else if (op == ccv_pkg::OP_CYL_CART)
        send_request(op, rand_coord(), rand_angle(), rand_coord());
      else if (op == ccv_pkg::OP_SPH_CART || op == ccv_pkg::OP_SPH_CYL)
        send_request(op, rand_coord(), rand_angle(), rand_angle());
      else if (op == ccv_pkg::OP_CYL_SPH)
        send_request(op, rand_coord(), rand_angle(), rand_coord());
      else
        send_request(op, rand_coord(), rand_coord(), rand_coord());
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ccv_pkg.sv
hdl/ccv_front.sv
hdl/ccv_cordic.sv
hdl/coordinate_system_converter.sv
hdl/ccv_checker.sv
test/coordinate_system_converter_check.sv
test/coordinate_system_converter_test.sv
